/* hdl/multidrop_frame_transmit_encoder_defines.svh */
// ----------------------------------------------------------------------------
// Multidrop frame transmit encoder assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef MULTIDROP_FRAME_TRANSMIT_ENCODER_DEFINES_SVH
`define MULTIDROP_FRAME_TRANSMIT_ENCODER_DEFINES_SVH

`ifndef ASSERT_OFF
`define MFTE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MFTE_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define MFTE_ASSERT(label, clk, rst, prop, msg)
`define MFTE_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

/* hdl/mfte_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multidrop frame transmit encoder package
// Field widths, register map, frame constants and the CRC byte update.
// ----------------------------------------------------------------------------
package mfte_pkg;

   localparam int unsigned ADDR_W  = 4;
   localparam int unsigned LEN_W   = 6;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CRC_W   = 16;
   localparam int unsigned BEATS   = 5;
   localparam int unsigned CNT_W   = $clog2(BEATS + 1);

   localparam logic [LEN_W-1:0]  PAYLOAD_LIMIT  = 6'd63;
   localparam logic [ADDR_W-1:0] BROADCAST_ADDR = 4'b1111;
   localparam logic [CRC_W-1:0]  CRC_INIT       = 16'hFFFF;
   localparam logic [CRC_W-1:0]  CRC_POLY       = 16'h1021;

   localparam logic FUNC_HEADER  = 1'b0;
   localparam logic FUNC_PAYLOAD = 1'b1;

   typedef enum logic [1:0] {
      REG_OWN_ADDRESS  = 2'd0,
      REG_PAYLOAD_CTRL = 2'd1,
      REG_ACK_FLAG     = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              mark;
      logic              last;
   } beat_type;

   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* hdl/multidrop_frame_transmit_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multidrop frame transmit encoder
// Builds 9-bit multidrop frames: three header bytes, then payload and CRC-16 if ctrl matches payload ctrl.
// ----------------------------------------------------------------------------
// Input transactions on req_*: tuser selects header (0) or payload byte (1).
// Each accepted item is encoded into a five-entry output buffer;
// its bytes leave on rsp_* one per cycle while rsp_tready is high, address mark
// in rsp_tuser and the final byte of a frame flagged by rsp_tlast.
// The first result byte is valid in the cycle after acceptance.
// Throughput: a payload item yields one byte (three on the last one) and a
// header item three bytes (five for an empty data frame); the output buffer
// drains one byte per cycle unless stalled, so req_tready is high again in the
// cycle the last byte is taken. Unstalled, payload bytes stream one per cycle.
// Stray payload bytes give no output. A header aborts any open frame.
// Reset: synchronous, empties the buffer, closes any frame, loads the CRC seed
// and the register defaults (own address 0, payload ctrl 0, ack flag 1).
// When the receiver stalls, the buffer holds and req_tready stays low while
// any byte is still pending.
// Configuration via the csr_* APB port, registers at 0x0, 0x4, 0x8.
// ----------------------------------------------------------------------------
`include "multidrop_frame_transmit_encoder_defines.svh"

module multidrop_frame_transmit_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] dest_address, [4] ack_bit, [5] ctrl_bit, [11:6] length,
   // [19:12] data_byte, [23:20] zero
   input  logic [23:0] req_tdata,
   // [0] func
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_byte
   output logic [7:0]  rsp_tdata,
   // [0] address_mark
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [mfte_pkg::ADDR_W-1:0] own_address_ff;
   logic                        payload_ctrl_ff;
   logic                        ack_flag_ff;

   logic                        frame_open_ff, frame_open_in;
   logic [mfte_pkg::LEN_W-1:0]  bytes_left_ff, bytes_left_in;
   logic [mfte_pkg::CRC_W-1:0]  crc_ff, crc_in;
   logic [mfte_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   mfte_pkg::beat_type          beat_ff [mfte_pkg::BEATS];
   mfte_pkg::beat_type          beat_in [mfte_pkg::BEATS];

   logic                        req_fire, rsp_fire, csr_write;
   logic [mfte_pkg::ADDR_W-1:0] dest;
   logic                        ack_eff;
   logic                        ctrl;
   logic [mfte_pkg::LEN_W-1:0]  len_raw, len_sat;
   logic [mfte_pkg::BYTE_W-1:0] data_byte;
   logic [mfte_pkg::BYTE_W-1:0] hdr0, hdr1, hdr2;
   logic [mfte_pkg::CRC_W-1:0]  crc_next;
   logic [mfte_pkg::LEN_W-1:0]  left_next;

   assign dest      = req_tdata[3:0];
   assign ctrl      = req_tdata[5];
   assign len_raw   = req_tdata[11:6];
   assign data_byte = req_tdata[19:12];

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = beat_ff[0].data;
   assign rsp_tuser  = beat_ff[0].mark;
   assign rsp_tlast  = beat_ff[0].last;
   assign rsp_fire   = rsp_tvalid & rsp_tready;

   assign req_tready = (cnt_ff == '0) ||
                       ((cnt_ff == mfte_pkg::CNT_W'(1)) && rsp_tready);
   assign req_fire   = req_tvalid & req_tready;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      case (csr_paddr[3:2])
         mfte_pkg::REG_OWN_ADDRESS:  csr_prdata = {28'd0, own_address_ff};
         mfte_pkg::REG_PAYLOAD_CTRL: csr_prdata = {31'd0, payload_ctrl_ff};
         mfte_pkg::REG_ACK_FLAG:     csr_prdata = {31'd0, ack_flag_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff  <= '0;
         payload_ctrl_ff <= 1'b0;
         ack_flag_ff     <= 1'b1;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            mfte_pkg::REG_OWN_ADDRESS:  own_address_ff  <= csr_pwdata[3:0];
            mfte_pkg::REG_PAYLOAD_CTRL: payload_ctrl_ff <= csr_pwdata[0];
            mfte_pkg::REG_ACK_FLAG:     ack_flag_ff     <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // header bytes
   assign len_sat  = (len_raw > mfte_pkg::PAYLOAD_LIMIT) ? mfte_pkg::PAYLOAD_LIMIT : len_raw;
   assign ack_eff  = (dest == mfte_pkg::BROADCAST_ADDR) ? ~ack_flag_ff : req_tdata[4];
   assign hdr0     = {own_address_ff, dest};
   assign hdr1     = {ack_eff, ctrl, len_sat};
   assign hdr2     = hdr0 ^ hdr1;

   // payload update
   assign crc_next  = mfte_pkg::crc_byte(crc_ff, data_byte);
   assign left_next = bytes_left_ff - mfte_pkg::LEN_W'(1);

   always_comb begin
      frame_open_in = frame_open_ff;
      bytes_left_in = bytes_left_ff;
      crc_in        = crc_ff;
      cnt_in        = cnt_ff;
      for (int i = 0; i < mfte_pkg::BEATS; i++) begin
         beat_in[i] = beat_ff[i];
      end
      if (rsp_fire) begin
         cnt_in = cnt_ff - mfte_pkg::CNT_W'(1);
         for (int i = 0; i < mfte_pkg::BEATS - 1; i++) begin
            beat_in[i] = beat_ff[i+1];
         end
      end
      if (req_fire) begin
         if (req_tuser == mfte_pkg::FUNC_HEADER) begin
            crc_in        = mfte_pkg::CRC_INIT;
            frame_open_in = 1'b0;
            bytes_left_in = '0;
            beat_in[0]    = '{data: hdr0, mark: 1'b1, last: 1'b0};
            beat_in[1]    = '{data: hdr1, mark: 1'b0, last: 1'b0};
            cnt_in        = mfte_pkg::CNT_W'(3);
            if (ctrl != payload_ctrl_ff) begin
               beat_in[2] = '{data: hdr2, mark: 1'b0, last: 1'b1};
            end else begin
               beat_in[2] = '{data: hdr2, mark: 1'b0, last: 1'b0};
               if (len_sat == '0) begin
                  beat_in[3] = '{data: mfte_pkg::CRC_INIT[15:8], mark: 1'b0, last: 1'b0};
                  beat_in[4] = '{data: mfte_pkg::CRC_INIT[7:0], mark: 1'b0, last: 1'b1};
                  cnt_in     = mfte_pkg::CNT_W'(5);
               end else begin
                  frame_open_in = 1'b1;
                  bytes_left_in = len_sat;
               end
            end
         end else if (frame_open_ff) begin
            crc_in        = crc_next;
            bytes_left_in = left_next;
            beat_in[0]    = '{data: data_byte, mark: 1'b0, last: 1'b0};
            cnt_in        = mfte_pkg::CNT_W'(1);
            if (left_next == '0) begin
               beat_in[1]    = '{data: crc_next[15:8], mark: 1'b0, last: 1'b0};
               beat_in[2]    = '{data: crc_next[7:0], mark: 1'b0, last: 1'b1};
               cnt_in        = mfte_pkg::CNT_W'(3);
               frame_open_in = 1'b0;
               crc_in        = mfte_pkg::CRC_INIT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         bytes_left_ff <= '0;
         crc_ff        <= mfte_pkg::CRC_INIT;
         cnt_ff        <= '0;
      end else begin
         frame_open_ff <= frame_open_in;
         bytes_left_ff <= bytes_left_in;
         crc_ff        <= crc_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < mfte_pkg::BEATS; i++) begin
         beat_ff[i] <= beat_in[i];
      end
   end

   `MFTE_ASSERT_NEVER(a_cnt_range, clock, reset, cnt_ff > mfte_pkg::CNT_W'(mfte_pkg::BEATS), "buffer count out of range")
   `MFTE_ASSERT(a_open_left, clock, reset, frame_open_ff |-> (bytes_left_ff != '0), "open frame with no bytes left")
   `MFTE_ASSERT(a_hdr_mark, clock, reset, (req_fire && (req_tuser == mfte_pkg::FUNC_HEADER)) |=> (rsp_tvalid && rsp_tuser), "header not led by address mark")
   `MFTE_ASSERT_NEVER(a_mark_last, clock, reset, rsp_tvalid && rsp_tuser && rsp_tlast, "address mark on frame end")
   `MFTE_ASSERT(a_closed_crc, clock, reset, !frame_open_ff |-> (crc_ff == mfte_pkg::CRC_INIT), "closed frame with CRC not seeded")

endmodule
